[rtl/core/uqp_pkg.sv]
// ----------------------------------------------------------------------------
// uqp_pkg: shared types and helpers for the URL query parameter parser
// Result record, per-byte result bundle, character codes and the hex decoder.
// ----------------------------------------------------------------------------
package uqp_pkg;

	// Most results a single input byte can cause
	localparam int NumRes = 5;
	localparam int CntW   = $clog2(NumRes + 1);

	// Depth of the queue between front and back
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		KIND_KEY       = 2'd0,
		KIND_VALUE     = 2'd1,
		KIND_END_PARAM = 2'd2,
		KIND_END_URL   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HEX  = 2'd2
	} esc_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// All results of one input byte, in order
	typedef struct packed {
		logic [CntW-1:0]         cnt;
		res_t [NumRes-1:0]       res;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Append one result to a bundle
	function automatic desc_t desc_add(desc_t d, kind_t k, logic [7:0] b);
		desc_t r;
		r = d;
		if (d.cnt < CntW'(NumRes)) begin
			r.res[d.cnt].kind = k;
			r.res[d.cnt].data = b;
			r.cnt = d.cnt + CntW'(1);
		end
		return r;
	endfunction

	// Emit a pending escape literally
	function automatic desc_t flush_esc(desc_t d, esc_t esc, logic [7:0] held, kind_t k);
		desc_t r;
		r = d;
		if (esc == ESC_PCT || esc == ESC_HEX) begin
			r = desc_add(r, k, CH_PCT);
		end
		if (esc == ESC_HEX) begin
			r = desc_add(r, k, held);
		end
		return r;
	endfunction

	// {is_hex, nibble}
	function automatic logic [4:0] hex_dec(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

[rtl/core/uqp_front.sv]
// ----------------------------------------------------------------------------
// uqp_front: byte classifier and parse state
// Takes one URL byte per beat and builds the bundle of results it causes.
// ----------------------------------------------------------------------------
module uqp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     url_byte,
	input  logic           url_end,
	output logic           push,
	output uqp_pkg::desc_t push_desc
);
	import uqp_pkg::*;

	typedef enum logic [1:0] {
		PH_BEFORE = 2'd0,
		PH_IN     = 2'd1,
		PH_AFTER  = 2'd2
	} phase_t;

	phase_t     phase_q, ph;
	logic       hbq_q, hbq;
	logic       inv_q, inv;
	esc_t       esc_q, esc;
	logic [7:0] held_q, held;
	logic       ne_q, ne;
	desc_t      d;
	logic [4:0] hv;
	logic [4:0] hh;
	logic       raw;
	kind_t      dk;

	always_comb begin
		ph   = phase_q;
		hbq  = hbq_q;
		inv  = inv_q;
		esc  = esc_q;
		held = held_q;
		ne   = ne_q;
		d    = '0;
		hv   = hex_dec(url_byte);
		hh   = hex_dec(held_q);
		raw  = 1'b0;
		dk   = inv_q ? KIND_VALUE : KIND_KEY;

		case (phase_q)
			PH_BEFORE: begin
				if (url_byte == CH_QUEST) begin
					ph  = PH_IN;
					ne  = 1'b0;
					inv = 1'b0;
					esc = ESC_NONE;
				end else if (url_byte == CH_HASH) begin
					hbq = 1'b1;
				end
			end
			PH_IN: begin
				if (url_byte == CH_HASH && !hbq_q) begin
					if (ne_q) begin
						d = flush_esc(d, esc_q, held_q, dk);
						d = desc_add(d, KIND_END_PARAM, 8'h00);
					end
					ne  = 1'b0;
					inv = 1'b0;
					esc = ESC_NONE;
					ph  = PH_AFTER;
				end else if (url_byte == CH_AMP) begin
					d   = flush_esc(d, esc_q, held_q, dk);
					d   = desc_add(d, KIND_END_PARAM, 8'h00);
					esc = ESC_NONE;
					ne  = 1'b0;
					inv = 1'b0;
				end else if (url_byte == CH_EQ && !inv_q) begin
					ne  = 1'b1;
					d   = flush_esc(d, esc_q, held_q, dk);
					esc = ESC_NONE;
					inv = 1'b1;
				end else begin
					ne  = 1'b1;
					raw = 1'b1;
					if (esc_q == ESC_PCT) begin
						if (hv[4]) begin
							held = url_byte;
							esc  = ESC_HEX;
							raw  = 1'b0;
						end else begin
							d   = flush_esc(d, esc_q, held_q, dk);
							esc = ESC_NONE;
						end
					end else if (esc_q == ESC_HEX) begin
						if (hv[4]) begin
							d   = desc_add(d, dk, {hh[3:0], hv[3:0]});
							esc = ESC_NONE;
							raw = 1'b0;
						end else begin
							d   = flush_esc(d, esc_q, held_q, dk);
							esc = ESC_NONE;
						end
					end
					if (raw) begin
						if (url_byte == CH_PCT) begin
							esc = ESC_PCT;
						end else if (url_byte == CH_PLUS) begin
							d = desc_add(d, dk, CH_SPACE);
						end else begin
							d = desc_add(d, dk, url_byte);
						end
					end
				end
			end
			default: ;
		endcase

		// close the query and the URL on the final byte
		if (url_end) begin
			if (ph == PH_IN && ne) begin
				d = flush_esc(d, esc, held, inv ? KIND_VALUE : KIND_KEY);
				d = desc_add(d, KIND_END_PARAM, 8'h00);
			end
			d    = desc_add(d, KIND_END_URL, 8'h00);
			ph   = PH_BEFORE;
			hbq  = 1'b0;
			inv  = 1'b0;
			esc  = ESC_NONE;
			held = 8'h00;
			ne   = 1'b0;
		end
	end

	assign push      = accept && (d.cnt != '0);
	assign push_desc = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BEFORE;
			hbq_q   <= 1'b0;
			inv_q   <= 1'b0;
			esc_q   <= ESC_NONE;
			held_q  <= 8'h00;
			ne_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= ph;
			hbq_q   <= hbq;
			inv_q   <= inv;
			esc_q   <= esc;
			held_q  <= held;
			ne_q    <= ne;
		end
	end

endmodule

[rtl/core/uqp_queue.sv]
// ----------------------------------------------------------------------------
// uqp_queue: short queue of result bundles
// Decouples the classifier from the result serializer.
// ----------------------------------------------------------------------------
module uqp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  uqp_pkg::desc_t   push_desc,
	input  logic             pop,
	output uqp_pkg::desc_t   head,
	output uqp_pkg::q_stat_t stat
);
	import uqp_pkg::*;

	desc_t          mem_q [QDepth];
	logic [QAw-1:0] wr_q, rd_q;
	logic [QAw:0]   cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == (QAw+1)'(QDepth));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAw'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAw'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QAw+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAw+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/uqp_back.sv]
// ----------------------------------------------------------------------------
// uqp_back: result serializer
// Walks the head bundle one result per beat into the output register.
// ----------------------------------------------------------------------------
module uqp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  uqp_pkg::desc_t   head,
	input  uqp_pkg::q_stat_t stat,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output uqp_pkg::res_t    out_res,
	output logic             out_last
);
	import uqp_pkg::*;

	logic [CntW-1:0] idx_q;
	logic            out_valid_q;
	res_t            res_q;
	logic            last_q;
	logic            load, take, at_last;

	assign load    = !out_valid_q || !out_stall;
	assign take    = load && !stat.empty;
	assign at_last = (idx_q == head.cnt - CntW'(1));
	assign pop     = take && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= !stat.empty;
			if (take) begin
				idx_q <= at_last ? '0 : idx_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q  <= head.res[idx_q];
			last_q <= at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

endmodule

[rtl/core/url_query_param_parser.sv]
// ----------------------------------------------------------------------------
// url_query_param_parser: streaming URL query parameter decoder
// Takes a URL byte by byte and emits decoded key bytes, value bytes,
// end-of-parameter and end-of-URL marks.
// ----------------------------------------------------------------------------
//
//  channel | beat contents            | handshake
//  --------+--------------------------+----------------------
//  in      | url_byte, url_end        | in_valid / in_stall
//  out     | kind, out_byte, run_last | out_valid / out_stall
//
//  A URL byte is taken every cycle while the bundle queue has room; the
//  classifier decides all results of a byte in the cycle it arrives.
//  The serializer delivers one result per cycle while out_stall is low,
//  so a byte causing up to five results (escape flush plus end marks)
//  keeps the output busy with them in turn; the four-deep queue absorbs
//  such bursts; a result passes through the queue, then the output register.
//  Reset clears the parse state, empties the queue and clears out_valid.
//
module url_query_param_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] url_byte,
	input  logic       url_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import uqp_pkg::*;

	logic    accept, push, pop;
	desc_t   push_desc, head;
	q_stat_t q_stat;
	res_t    out_res;

	// hold input while the queue is full
	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	uqp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.url_byte  (url_byte),
		.url_end   (url_end),
		.push      (push),
		.push_desc (push_desc)
	);

	uqp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	uqp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (q_stat),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_last  (run_last)
	);

	assign kind     = out_res.kind;
	assign out_byte = out_res.data;

`ifndef SYNTH
	// never write a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("bundle queue overflow");

	// never drain an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("bundle queue underflow");

	// end of URL always closes its byte's run, with a zero byte
	a_end_url_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_END_URL) |-> run_last && (out_byte == 8'h00))
		else $error("end of URL not last in run");
`endif

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the URL query parameter parser
// Streams URLs into the parser one byte per beat and checks every result
// beat against a software decoder of the query string. Both sides idle at
// random, and one long output hold-off fills the block so it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
	import uqp_pkg::*;

	// Watchdog limit and quiet time after the last expected result
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 150;
	localparam int MAX_REPORTS  = 40;

	typedef enum logic [1:0] {
		PH_PRE   = 2'd0,
		PH_QUERY = 2'd1,
		PH_POST  = 2'd2
	} phase_e;

	// One decoded result beat as the parser should deliver it
	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} token_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] url_byte = 8'h00;
	logic       url_end = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       run_last;

	url_query_param_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.url_byte (url_byte),
		.url_end  (url_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.out_byte (out_byte),
		.run_last (run_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Decoder state, a private copy of what the parser should hold
	// ------------------------------------------------------------------
	phase_e     url_phase;
	logic       hash_seen;
	logic       in_val;
	esc_t       esc;
	logic [7:0] held_digit;
	logic       item_used;

	token_t byte_tokens[$];   // results of the byte being decoded
	token_t want_tokens[$];   // results still owed by the parser

	int n_fail   = 0;
	int n_sent   = 0;
	int cycles   = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int hold_reqs  = 0;

	string hex_digits = "0123456789abcdefABCDEF";

	function automatic int hex_nibble(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic void emit(kind_t k, logic [7:0] b);
		token_t t;
		t.kind = k;
		t.data = b;
		t.last = 1'b0;
		byte_tokens.insert(byte_tokens.size(), t);
	endfunction

	function automatic void emit_data(logic [7:0] b);
		emit(in_val ? KIND_VALUE : KIND_KEY, b);
	endfunction

	// Pass a pending escape through literally
	function automatic void flush_pending();
		if (esc != ESC_NONE) emit_data(CH_PCT);
		if (esc == ESC_HEX) emit_data(held_digit);
		esc = ESC_NONE;
	endfunction

	function automatic void put_char(logic [7:0] c);
		int v;
		int h;
		v = hex_nibble(c);
		if (esc == ESC_PCT) begin
			if (v >= 0) begin
				held_digit = c;
				esc = ESC_HEX;
				return;
			end
			flush_pending();
		end else if (esc == ESC_HEX) begin
			if (v >= 0) begin
				h = hex_nibble(held_digit);
				if (h < 0) h = 0;
				emit_data({h[3:0], v[3:0]});
				esc = ESC_NONE;
				return;
			end
			flush_pending();
		end
		if (c == CH_PCT) esc = ESC_PCT;
		else if (c == CH_PLUS) emit_data(CH_SPACE);
		else emit_data(c);
	endfunction

	// Close the query: only a non-empty item gets its end mark
	function automatic void close_query();
		if (item_used) begin
			flush_pending();
			emit(KIND_END_PARAM, 8'h00);
		end
		item_used = 1'b0;
		in_val = 1'b0;
		esc = ESC_NONE;
	endfunction

	function automatic void clear_parse();
		url_phase  = PH_PRE;
		hash_seen  = 1'b0;
		in_val     = 1'b0;
		esc        = ESC_NONE;
		held_digit = 8'h00;
		item_used  = 1'b0;
	endfunction

	// Decode one accepted byte and queue the results it owes
	function automatic void parse_byte(logic [7:0] c, logic last_byte);
		byte_tokens.delete();
		case (url_phase)
			PH_PRE: begin
				if (c == CH_QUEST) begin
					url_phase = PH_QUERY;
					item_used = 1'b0;
					in_val = 1'b0;
					esc = ESC_NONE;
				end else if (c == CH_HASH) begin
					hash_seen = 1'b1;
				end
			end
			PH_QUERY: begin
				if (c == CH_HASH && !hash_seen) begin
					close_query();
					url_phase = PH_POST;
				end else if (c == CH_AMP) begin
					flush_pending();
					emit(KIND_END_PARAM, 8'h00);
					item_used = 1'b0;
					in_val = 1'b0;
				end else if (c == CH_EQ && !in_val) begin
					item_used = 1'b1;
					flush_pending();
					in_val = 1'b1;
				end else begin
					item_used = 1'b1;
					put_char(c);
				end
			end
			default: ;
		endcase
		if (last_byte) begin
			if (url_phase == PH_QUERY) close_query();
			emit(KIND_END_URL, 8'h00);
			clear_parse();
		end
		if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
		foreach (byte_tokens[i]) want_tokens.insert(want_tokens.size(), byte_tokens[i]);
	endfunction

	// ------------------------------------------------------------------
	// Watchdog: end the run at the cycle limit even while results keep coming
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Output side: random stall, plus a long hold-off on request.
	// The hold is counted here so the sender keeps offering beats.
	// ------------------------------------------------------------------
	int hold_left = 0;
	int hold_seen = 0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= rx_idle_en && ($urandom_range(99) < 36);
		end
	end

	// ------------------------------------------------------------------
	// Result checking: every accepted beat against the oldest expectation
	// ------------------------------------------------------------------
	function automatic void mismatch(string field, int exp_v, int got_v);
		n_fail++;
		if (n_fail <= MAX_REPORTS)
			$error("%s: expected %0d, actual %0d", field, exp_v, got_v);
	endfunction

	always @(posedge clk) begin : check_results
		token_t t;
		if (arst_n && out_valid && !out_stall) begin
			if (want_tokens.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$error("result beat with nothing expected: kind %0d byte %0d",
						kind, out_byte);
			end else begin
				t = want_tokens.pop_front();
				if (kind !== t.kind) mismatch("kind", t.kind, kind);
				if (out_byte !== t.data) mismatch("out_byte", t.data, out_byte);
				if (run_last !== t.last) mismatch("run_last", t.last, run_last);
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one byte, hold it until taken, then decode it.
	// Called at a rising edge; leaves valid high for the next beat.
	task automatic send_beat(logic [7:0] b, logic last_byte);
		if (tx_idle_en && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 36);
		end
		in_valid <= 1'b1;
		url_byte <= b;
		url_end  <= last_byte;
		do @(posedge clk); while (in_stall);
		parse_byte(b, last_byte);
		n_sent++;
	endtask

	task automatic send_text(string s, bit mark_end);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], mark_end && (i == s.len() - 1));
	endtask

	// Bias toward the characters that steer the parser
	function automatic logic [7:0] query_char();
		int r;
		r = $urandom_range(99);
		if (r < 30) return hex_digits[$urandom_range(21)];
		if (r < 42) return 8'($urandom_range("g", "z"));
		if (r < 52) return CH_PCT;
		if (r < 58) return CH_PLUS;
		if (r < 66) return CH_EQ;
		if (r < 75) return CH_AMP;
		if (r < 79) return CH_HASH;
		if (r < 82) return CH_QUEST;
		return 8'($urandom_range(255));
	endfunction

	// A mostly well-formed URL: junk path, '?', query, maybe a fragment
	task automatic send_random_url();
		logic [7:0] url[$];
		logic [7:0] c;
		int n;
		n = $urandom_range(0, 3);
		repeat (n) begin
			c = ($urandom_range(7) == 0) ? CH_HASH : 8'($urandom_range(255));
			if (c == CH_QUEST) c = CH_AMP;
			url.insert(url.size(), c);
		end
		if ($urandom_range(9) != 0) url.insert(url.size(), CH_QUEST);
		n = $urandom_range(0, 14);
		repeat (n) url.insert(url.size(), query_char());
		if ($urandom_range(3) == 0) begin
			url.insert(url.size(), CH_HASH);
			n = $urandom_range(0, 3);
			repeat (n) url.insert(url.size(), query_char());
		end
		if (url.size() == 0) url.insert(url.size(), CH_QUEST);
		foreach (url[i]) send_beat(url[i], i == url.size() - 1);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked URLs for the corner cases of the decoder
	task automatic test_directed();
		// Extreme bytes and a hash ahead of the query; inside the query the
		// later hash is data, then bad escapes, later '=', plus, empty items,
		// an escape pending at '&' and one pending at the end of the URL
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_text("#?a%4x#=b=+%6A&%4&&%g%", 1'b1);
		// Most results from one byte: escape flush, data, both end marks
		send_text("?k%4", 1'b0);
		send_beat(8'hFF, 1'b1);
		// Escape pending at '=', fragment closes the query, trailing bytes
		send_text("x?%=1#b", 1'b1);
		// Empty query
		send_text("?", 1'b1);
	endtask

	task automatic test_random_urls(int n_bytes);
		int stop_at;
		stop_at = n_sent + n_bytes;
		while (n_sent < stop_at) send_random_url();
	endtask

	// Full rate on both sides for a stretch
	task automatic test_no_idle();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_urls(50);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Hold the output for a long while and keep feeding until input stalls
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		hold_reqs++;
		test_random_urls(40);
		tx_idle_en = 1'b1;
	endtask

	// Raw bytes with scattered end marks
	task automatic test_noise();
		repeat (40) send_beat(8'($urandom_range(255)), $urandom_range(15) == 0);
		send_beat(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		clear_parse();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_urls(80);
		test_no_idle();
		test_backpressure();
		test_noise();

		// Drop valid, wait for the owed results, then a quiet spell
		in_valid <= 1'b0;
		url_end  <= 1'b0;
		while (want_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_fail == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
